### rtl/swfd_pkg.sv
// Shared constants and types for the single-wire pulse-width frame decoder.
package swfd_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WidthW    = 16;
  localparam int unsigned CntW      = 6;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [ByteW-1:0] OneThrRst  = 8'd40;
  localparam logic [ByteW-1:0] RespMinRst = 8'd75;
  localparam logic [ByteW-1:0] RespMaxRst = 8'd100;

  // Count value held before the last bit of a frame is shifted in
  localparam logic [CntW-1:0] LastBitCnt = CntW'(FrameBits - 1);

  // Register index, taken from the word-aligned address
  typedef enum logic [1:0] {
    RegOneThr  = 2'd0,
    RegRespMin = 2'd1,
    RegRespMax = 2'd2
  } reg_idx_t;

  // Line level after an edge
  localparam logic LevelFall = 1'b0;

endpackage

### rtl/single_wire_pulse_width_frame_decoder.sv
// Top level: single-wire pulse-width frame decoder with APB register port.
//
//  channel | ports                               | direction | handshake
//  --------+-------------------------------------+-----------+-------------------
//  in      | in_line_level, in_high_time_us      | input     | in_valid / in_stall
//  out     | out_byte_zero .. out_byte_four      | output    | out_valid / out_stall
//  cfg     | psel penable pwrite paddr pwdata .. | input     | APB, pready high
//
// One edge word is taken per cycle while in_stall is low. A word is decoded
// in the input register; a completed frame enters the output register as
// its closing word leaves the input register, raising out_valid. The input
// side stalls only while a frame-completing word waits for the output
// register to drain; all other words pass through a full output. Reset is
// synchronous, active low, and restores the register defaults.
module single_wire_pulse_width_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_line_level,
  input  logic [swfd_pkg::WidthW-1:0]   in_high_time_us,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swfd_pkg::ByteW-1:0]    out_byte_zero,
  output logic [swfd_pkg::ByteW-1:0]    out_byte_one,
  output logic [swfd_pkg::ByteW-1:0]    out_byte_two,
  output logic [swfd_pkg::ByteW-1:0]    out_byte_three,
  output logic [swfd_pkg::ByteW-1:0]    out_byte_four,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swfd_pkg::AddrW-1:0]    paddr,
  input  logic [swfd_pkg::DataW-1:0]    pwdata,
  output logic [swfd_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [swfd_pkg::ByteW-1:0] one_thr_r;
  logic [swfd_pkg::ByteW-1:0] resp_min_r;
  logic [swfd_pkg::ByteW-1:0] resp_max_r;

  // input register
  logic                        s1_valid_r;
  logic                        s1_level_r;
  logic [swfd_pkg::WidthW-1:0] s1_width_r;

  // decoder state
  logic                           resp_r;
  logic                           resp_nxt;
  logic [swfd_pkg::CntW-1:0]      bit_cnt_r;
  logic [swfd_pkg::CntW-1:0]      bit_cnt_nxt;
  logic [swfd_pkg::FrameBits-1:0] shift_r;
  logic [swfd_pkg::FrameBits-1:0] shift_nxt;

  // output register
  logic                           out_valid_r;
  logic [swfd_pkg::FrameBits-1:0] out_frame_r;

  logic           cfg_wr;
  swfd_pkg::reg_idx_t cfg_idx;
  logic           falling;
  logic           data_bit;
  logic           in_window;
  logic           produce;
  logic           out_free;
  logic           s1_advance;
  logic           in_take;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = swfd_pkg::reg_idx_t'(paddr[swfd_pkg::AddrW-1:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_thr_r  <= swfd_pkg::OneThrRst;
      resp_min_r <= swfd_pkg::RespMinRst;
      resp_max_r <= swfd_pkg::RespMaxRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        swfd_pkg::RegOneThr:  one_thr_r  <= pwdata[swfd_pkg::ByteW-1:0];
        swfd_pkg::RegRespMin: resp_min_r <= pwdata[swfd_pkg::ByteW-1:0];
        swfd_pkg::RegRespMax: resp_max_r <= pwdata[swfd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      swfd_pkg::RegOneThr:  prdata = {{(swfd_pkg::DataW-swfd_pkg::ByteW){1'b0}}, one_thr_r};
      swfd_pkg::RegRespMin: prdata = {{(swfd_pkg::DataW-swfd_pkg::ByteW){1'b0}}, resp_min_r};
      swfd_pkg::RegRespMax: prdata = {{(swfd_pkg::DataW-swfd_pkg::ByteW){1'b0}}, resp_max_r};
      default:              prdata = '0;
    endcase
  end

  // Decode the registered edge word
  always_comb begin
    falling   = s1_valid_r && (s1_level_r == swfd_pkg::LevelFall);
    data_bit  = s1_width_r > {{(swfd_pkg::WidthW-swfd_pkg::ByteW){1'b0}}, one_thr_r};
    in_window = (s1_width_r >= {{(swfd_pkg::WidthW-swfd_pkg::ByteW){1'b0}}, resp_min_r}) &&
                (s1_width_r <= {{(swfd_pkg::WidthW-swfd_pkg::ByteW){1'b0}}, resp_max_r});
    produce   = falling && resp_r && (bit_cnt_r >= swfd_pkg::LastBitCnt);

    resp_nxt    = resp_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    if (falling && resp_r) begin
      shift_nxt   = {shift_r[swfd_pkg::FrameBits-2:0], data_bit};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
      if (produce) begin
        bit_cnt_nxt = '0;
        resp_nxt    = 1'b0;
      end
    end
    if (falling && in_window) begin
      resp_nxt = 1'b1;
    end
  end

  // Hold a frame-completing word only while the output is occupied and stalled
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && (!produce || out_free);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_line_level;
      s1_width_r <= in_high_time_us;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else if (s1_advance) begin
      resp_r    <= resp_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      shift_r <= shift_nxt;
    end
  end

  // Load or drain the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && produce) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && produce) begin
      out_frame_r <= shift_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_zero  = out_frame_r[39:32];
  assign out_byte_one   = out_frame_r[31:24];
  assign out_byte_two   = out_frame_r[23:16];
  assign out_byte_three = out_frame_r[15:8];
  assign out_byte_four  = out_frame_r[7:0];

  // Count stays below a full frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= swfd_pkg::LastBitCnt)
    else $error("bit count beyond frame length");

  // Bits are only counted after a response pulse
  a_cnt_needs_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_cnt_r != '0) |-> resp_r)
    else $error("bit count nonzero without response flag");

  // A completed frame lands in the output register
  a_frame_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && produce) |=> (out_valid && (bit_cnt_r == '0)))
    else $error("completed frame not presented");

  // Input stalls only behind a waiting frame
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (produce && out_valid_r && out_stall))
    else $error("input stalled without a blocked frame");

endmodule
